// File: sv/lru_key_tracker_defines.svh
// ----------------------------------------------------------------------------
// lru_key_tracker_defines: assertion macros
// Shared shorthands for the concurrent checks of the key tracker.
// ----------------------------------------------------------------------------
`ifndef LRU_KEY_TRACKER_DEFINES_SVH
`define LRU_KEY_TRACKER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent
`define LKT_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define LKT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

// Consequent must hold later than the antecedent
`define LKT_ASSERT_DLY2(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> ##2 (cons)) \
		else $error(msg);

`endif

// File: sv/lkt_pkg.sv
// ----------------------------------------------------------------------------
// lkt_pkg: shared types and constants of the LRU key tracker
// Sizes, transaction payloads, command codes and the cell control bundle.
// ----------------------------------------------------------------------------
package lkt_pkg;

	localparam int DEPTH    = 16;
	localparam int KEY_BITS = 32;
	localparam int IDX_W    = $clog2(DEPTH);
	localparam int CNT_W    = $clog2(DEPTH + 1);
	localparam int CAP_W    = 5;
	localparam int OCC_W    = 5;
	localparam int CMP_W    = (CNT_W > CAP_W) ? CNT_W : CAP_W;

	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

	typedef enum logic {
		CMD_TOUCH  = 1'b0,
		CMD_REMOVE = 1'b1
	} cmd_t;

	// What the row of cells does in an update cycle
	typedef enum logic [1:0] {
		MODE_HOLD,
		MODE_INSERT,
		MODE_PROMOTE,
		MODE_DELETE
	} mode_t;

	typedef struct packed {
		cmd_t                command;
		logic [KEY_BITS-1:0] key;
	} in_t;

	typedef struct packed {
		logic                was_present;
		logic                evicted;
		logic [KEY_BITS-1:0] evicted_key;
		logic [OCC_W-1:0]    occupancy;
	} out_t;

	typedef struct packed {
		logic                cmp_en;
		logic [KEY_BITS-1:0] cmp_key;
		logic                upd_en;
		mode_t               mode;
		logic [CNT_W-1:0]    new_count;
	} ctl_t;

endpackage

// File: sv/lru_key_tracker.sv
// A transaction is compared in the cycle it is accepted; its result is registered in
// the cycle after. Each has a compare cycle, in which every cell checks its key, then
// a shift cycle, in which the cell row moves, the result is loaded and input is held off.
// A new transaction is held off while a stalled result waits at the output register.
// Reset clears the list (occupancy 0) and sets capacity to 16; stored keys are not cleared.
// ----------------------------------------------------------------------------
// lru_key_tracker: least-recently-used key list
// A row of cells keeps keys in recency order; touch promotes or inserts a key
// and evicts the oldest past capacity, remove deletes a key.
// ----------------------------------------------------------------------------
module lru_key_tracker
	import lkt_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  in_t              in_data,
	output logic             out_valid,
	input  logic             out_stall,
	output out_t             out_data,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [CAP_W-1:0] cfg_data
);

	typedef enum logic {
		ST_IDLE,
		ST_UPD
	} state_t;

	state_t              state_q;
	logic                out_valid_q;
	out_t                out_data_q;
	logic [CNT_W-1:0]    count_q;
	logic [CAP_W-1:0]    cap_q;
	cmd_t                cmd_q;
	logic [KEY_BITS-1:0] key_q;

	logic                accept;
	ctl_t                ctl;
	logic [CNT_W-1:0]    cap_eff;
	logic [CNT_W-1:0]    cnt_m1;
	logic [IDX_W-1:0]    last_idx;
	logic [IDX_W-1:0]    ev_idx;
	logic                hit;
	logic                ev;
	logic [KEY_BITS-1:0] ev_key;
	logic [CNT_W-1:0]    new_n;
	mode_t               mode;

	logic [KEY_BITS-1:0] key_c  [DEPTH];
	logic [KEY_BITS-1:0] prev_k [DEPTH];
	logic [KEY_BITS-1:0] next_k [DEPTH];
	logic [DEPTH-1:0]    match_v;
	logic [DEPTH:0]      lo_c;
	logic [DEPTH:0]      hi_c;

	assign accept    = in_valid && !in_stall;
	assign in_stall  = (state_q != ST_IDLE) || (out_valid_q && out_stall);
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// Neighbor wiring of the cell row
	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			prev_k[i] = (i == 0) ? key_q : key_c[(i == 0) ? 0 : i - 1];
			next_k[i] = (i == DEPTH - 1) ? '0 : key_c[(i == DEPTH - 1) ? i : i + 1];
		end
	end

	assign lo_c[0]     = 1'b0;
	assign hi_c[DEPTH] = 1'b0;
	assign hit         = lo_c[DEPTH];

	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		lkt_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.pos      (IDX_W'(g)),
			.ctl      (ctl),
			.prev_key (prev_k[g]),
			.next_key (next_k[g]),
			.lo_in    (lo_c[g]),
			.hi_in    (hi_c[g+1]),
			.key      (key_c[g]),
			.match    (match_v[g]),
			.lo_out   (lo_c[g+1]),
			.hi_out   (hi_c[g])
		);
	end

	// Clamp the capacity register into one to the list size
	always_comb begin
		if (cap_q == '0) begin
			cap_eff = CNT_W'(1);
		end else if (CMP_W'(cap_q) > CMP_W'(DEPTH)) begin
			cap_eff = CNT_W'(DEPTH);
		end else begin
			cap_eff = CNT_W'(cap_q);
		end
	end

	// Decide the row movement, eviction and new occupancy
	always_comb begin
		cnt_m1   = count_q - CNT_W'(1);
		last_idx = cnt_m1[IDX_W-1:0];
		ev_idx   = last_idx - IDX_W'(match_v[last_idx]);
		ev       = 1'b0;
		new_n    = count_q;
		mode     = MODE_HOLD;
		unique case (cmd_q)
			CMD_TOUCH: begin
				if (hit) begin
					mode  = MODE_PROMOTE;
					ev    = count_q > cap_eff;
					new_n = ev ? cnt_m1 : count_q;
				end else begin
					mode  = MODE_INSERT;
					ev    = count_q >= cap_eff;
					new_n = ev ? count_q : count_q + CNT_W'(1);
				end
			end
			CMD_REMOVE: begin
				if (hit) begin
					mode  = MODE_DELETE;
					new_n = cnt_m1;
				end
			end
			default: begin
			end
		endcase
		ev_key = ev ? key_c[ev_idx] : '0;
	end

	// Broadcast control to the cells
	always_comb begin
		ctl.cmp_en    = accept;
		ctl.cmp_key   = in_data.key;
		ctl.upd_en    = (state_q == ST_UPD);
		ctl.mode      = mode;
		ctl.new_count = new_n;
	end

	// Hold the command for the update cycle
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= in_data.command;
			key_q <= in_data.key;
		end
	end

	// Write the capacity register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg_valid && cfg_ready) begin
			cap_q <= cfg_data;
		end
	end

	// Sequence compare and update; load the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			out_data_q  <= '0;
			count_q     <= '0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_UPD;
					end
				end
				ST_UPD: begin
					state_q                <= ST_IDLE;
					count_q                <= new_n;
					out_valid_q            <= 1'b1;
					out_data_q.was_present <= hit;
					out_data_q.evicted     <= ev;
					out_data_q.evicted_key <= ev_key;
					out_data_q.occupancy   <= OCC_W'(new_n);
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// File: sv/lkt_cell.sv
// ----------------------------------------------------------------------------
// lkt_cell: one slot of the recency list
// Holds one key and its valid bit, compares against the broadcast key and
// shifts toward either neighbor under control of the broadcast mode.
// ----------------------------------------------------------------------------
module lkt_cell
	import lkt_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic [IDX_W-1:0]    pos,
	input  ctl_t                ctl,
	input  logic [KEY_BITS-1:0] prev_key,
	input  logic [KEY_BITS-1:0] next_key,
	input  logic                lo_in,
	input  logic                hi_in,
	output logic [KEY_BITS-1:0] key,
	output logic                match,
	output logic                lo_out,
	output logic                hi_out
);

	logic [KEY_BITS-1:0] key_q;
	logic                valid_q;
	logic                match_q;
	logic                take_prev;
	logic                take_next;

	// Pass the hit position along the row in both directions
	always_comb begin
		lo_out    = lo_in | match_q;
		hi_out    = hi_in | match_q;
		take_prev = 1'b0;
		take_next = 1'b0;
		unique case (ctl.mode)
			MODE_HOLD: begin
			end
			MODE_INSERT: begin
				take_prev = 1'b1;
			end
			MODE_PROMOTE: begin
				take_prev = hi_out;
			end
			MODE_DELETE: begin
				take_next = lo_out;
			end
			default: begin
			end
		endcase
	end

	// Shift the key toward the older or the newer end
	always_ff @(posedge clk) begin
		if (ctl.upd_en) begin
			if (take_prev) begin
				key_q <= prev_key;
			end else if (take_next) begin
				key_q <= next_key;
			end
		end
	end

	// Capture the compare result and refresh the valid bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			match_q <= 1'b0;
		end else begin
			if (ctl.cmp_en) begin
				match_q <= valid_q && (key_q == ctl.cmp_key);
			end
			if (ctl.upd_en) begin
				valid_q <= (CNT_W'(pos) < ctl.new_count);
			end
		end
	end

	assign key   = key_q;
	assign match = match_q;

endmodule

// File: sv/lkt_checker.sv
// ----------------------------------------------------------------------------
// lkt_checker: port-level checks of the LRU key tracker
// Watches transactions on the top level ports; attached by bind.
// ----------------------------------------------------------------------------
`include "lru_key_tracker_defines.svh"

module lkt_prop_checker
	import lkt_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_stall,
	input in_t  in_data,
	input logic out_valid,
	input logic out_stall,
	input out_t out_data
);

	logic in_take;
	logic rm_take;
	logic no_evict;

	assign in_take  = in_valid && !in_stall;
	assign rm_take  = in_take && (in_data.command == CMD_REMOVE);
	assign no_evict = out_valid && !out_data.evicted;

	// Occupancy never exceeds the list size
	`LKT_ASSERT_SAME(a_occ_bound, out_valid, out_data.occupancy <= OCC_W'(DEPTH), "occupancy too high")

	// Evicted key reads zero when nothing was dropped
	`LKT_ASSERT_SAME(a_evkey_zero, no_evict, out_data.evicted_key == '0, "stray evicted key")

	// Input is held off during the update cycle
	`LKT_ASSERT_NEXT(a_busy_stall, in_take, in_stall, "transaction accepted during update")

	// A remove's result shows up after its update cycle and never evicts
	`LKT_ASSERT_DLY2(a_remove_noev, rm_take, no_evict, "remove result missing or evicting")

	// A stalled result stays put
	`LKT_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "result moved")

endmodule

bind lru_key_tracker lkt_prop_checker u_lkt_checker (.*);
